/* rtl/prim_minimum_spanning_tree_core_macros.svh */
// Assertion macros shared by the minimum spanning tree RTL.
`ifndef PRIM_MINIMUM_SPANNING_TREE_CORE_MACROS_SVH
`define PRIM_MINIMUM_SPANNING_TREE_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PMST_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pmst assertion failed");

// Next-cycle implication, checked outside reset.
`define PMST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pmst assertion failed");

`endif

/* rtl/pmst_pkg.sv */
// Types, constants and register codes of the minimum spanning tree core.
`timescale 1ns / 1ps

package pmst_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int WEIGHT_BITS  = 32;
    localparam int VERTEX_BITS  = 6;
    localparam int VCOUNT_BITS  = 7;
    localparam int PADDR_BITS   = 3;
    localparam int PDATA_BITS   = 32;

    localparam logic [VCOUNT_BITS-1:0] VCOUNT_RESET = 7'd64;

    // Word index of the vertex count register (paddr bit 2)
    localparam logic REG_VERTEX_COUNT = 1'b0;

    // Key of a vertex that was never relaxed
    localparam logic signed [WEIGHT_BITS-1:0] KEY_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};

    typedef struct packed {
        logic [VERTEX_BITS-1:0]        first_end;
        logic [VERTEX_BITS-1:0]        second_end;
        logic signed [WEIGHT_BITS-1:0] edge_weight;
        logic                          edge_valid;
        logic                          last_edge;
    } t_edge_req;

    typedef struct packed {
        logic [VERTEX_BITS-1:0]        vertex_id;
        logic [VERTEX_BITS-1:0]        parent_id;
        logic signed [WEIGHT_BITS-1:0] tree_weight;
        logic                          reached;
        logic                          last_result;
    } t_tree_rsp;

    typedef enum logic [1:0] {
        CMP_LOAD,
        CMP_SEARCH,
        CMP_RELAX
    } t_cmp_op;

    typedef struct packed {
        t_cmp_op                       op;
        logic signed [WEIGHT_BITS-1:0] in_weight;
        logic signed [WEIGHT_BITS-1:0] adj_weight;
        logic signed [WEIGHT_BITS-1:0] node_key;
        logic signed [WEIGHT_BITS-1:0] best_key;
    } t_cmp_req;

endpackage

/* rtl/pmst_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module pmst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/pmst_cmp.sv */
// Shared signed less-than unit used by edge loading, key search and relaxation.
`timescale 1ns / 1ps

module pmst_cmp (
    input  pmst_pkg::t_cmp_req i_req,
    output logic               o_less
);

    logic signed [pmst_pkg::WEIGHT_BITS-1:0] lhs;
    logic signed [pmst_pkg::WEIGHT_BITS-1:0] rhs;

    // Pick the operand pair for the current step
    always_comb begin
        unique case (i_req.op)
            pmst_pkg::CMP_LOAD: begin
                lhs = i_req.in_weight;
                rhs = i_req.adj_weight;
            end
            pmst_pkg::CMP_SEARCH: begin
                lhs = i_req.node_key;
                rhs = i_req.best_key;
            end
            pmst_pkg::CMP_RELAX: begin
                lhs = i_req.adj_weight;
                rhs = i_req.node_key;
            end
            default: begin
                lhs = '0;
                rhs = '0;
            end
        endcase
    end

    assign o_less = lhs < rhs;

endmodule

/* rtl/prim_minimum_spanning_tree_core.sv */
// Top level of the minimum spanning tree core: register port, sequencer and storage.
`timescale 1ns / 1ps
`include "prim_minimum_spanning_tree_core_macros.svh"

// Edge requests build a symmetric adjacency matrix (smallest weight kept for
// parallel edges); the request flagged last_edge starts a dense Prim walk from
// vertex 0 over vertex_count vertices, after which one result per vertex
// 1..count-1 comes out in increasing order. An empty or out-of-range request
// is not stored; a stored edge is read, compared and, if new or lighter,
// written to both mirrored entries of the single-write-port matrix RAM in turn.
// The walk runs n rounds, each a key search and a relax scan through the one
// shared compare unit; each result is then read, registered and held until
// ready. After reset, and after a walk whose edges reached beyond the current
// vertex count, a clearing pass over all 2^(2*ceil(log2(MAX_VERTICES))) matrix
// entries (4096 by default) runs before requests are taken.
module prim_minimum_spanning_tree_core #(
    parameter int MAX_VERTICES = pmst_pkg::MAX_VERTICES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  pmst_pkg::t_edge_req               i_edge,
    output logic                              o_valid,
    input  logic                              i_ready,
    output pmst_pkg::t_tree_rsp               o_result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pmst_pkg::PADDR_BITS-1:0]   paddr,
    input  logic [pmst_pkg::PDATA_BITS-1:0]   pwdata,
    output logic [pmst_pkg::PDATA_BITS-1:0]   prdata,
    output logic                              pready
);

    localparam int VW        = $clog2(MAX_VERTICES);
    localparam int CW        = $clog2(MAX_VERTICES + 1);
    localparam int AW        = 2 * VW;
    localparam int ADJ_DEPTH = 1 << AW;
    localparam int W         = pmst_pkg::WEIGHT_BITS;
    localparam int NODE_W    = W + VW;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LREAD,
        S_LCMP,
        S_LMIRROR,
        S_SEARCH,
        S_RELAX,
        S_ORD,
        S_OLOAD,
        S_OWAIT,
        S_FINISH
    } t_state;

    t_state                           r_st;
    logic [pmst_pkg::VCOUNT_BITS-1:0] r_vcount;
    pmst_pkg::t_edge_req              r_item;
    logic [CW-1:0]                    r_scan;
    logic                             r_rd_vld;
    logic [VW-1:0]                    r_rd_idx;
    logic [CW-1:0]                    r_round;
    logic [VW-1:0]                    r_best;
    logic signed [W-1:0]              r_best_key;
    logic                             r_found;
    logic [MAX_VERTICES-1:0]          r_visited;
    logic [MAX_VERTICES-1:0]          r_reached;
    logic [CW-1:0]                    r_span;
    logic [AW-1:0]                    r_clr;
    logic                             r_out_valid;
    pmst_pkg::t_tree_rsp              r_out;

    logic [CW-1:0]       eff_n;
    logic                cfg_write;
    logic                in_range;
    logic [VW-1:0]       item_a;
    logic [VW-1:0]       item_b;
    logic [CW-1:0]       item_hi;
    logic [VW-1:0]       scan_idx;

    logic                adj_we;
    logic [AW-1:0]       adj_waddr;
    logic [W:0]          adj_wdata;
    logic [AW-1:0]       adj_raddr;
    logic [W:0]          adj_rdata;
    logic                adj_present;
    logic signed [W-1:0] adj_w;

    logic                node_we;
    logic [VW-1:0]       node_waddr;
    logic [NODE_W-1:0]   node_wdata;
    logic [VW-1:0]       node_raddr;
    logic [NODE_W-1:0]   node_rdata;
    logic signed [W-1:0] node_key_raw;
    logic signed [W-1:0] node_key;
    logic [VW-1:0]       node_par;

    pmst_pkg::t_cmp_req  cmp_req;
    logic                cmp_less;
    logic                load_upd;
    logic                search_take;
    logic                relax_hit;

    // Register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        if (paddr[2] == pmst_pkg::REG_VERTEX_COUNT) begin
            prdata = pmst_pkg::PDATA_BITS'(r_vcount);
        end else begin
            prdata = '0;
        end
    end

    // Saturate the vertex count into 1..MAX_VERTICES
    always_comb begin
        if (r_vcount == '0) begin
            eff_n = CW'(1);
        end else if (32'(r_vcount) > 32'(MAX_VERTICES)) begin
            eff_n = CW'(MAX_VERTICES);
        end else begin
            eff_n = CW'(r_vcount);
        end
    end

    assign in_range = (32'(i_edge.first_end) < 32'(eff_n)) &&
                      (32'(i_edge.second_end) < 32'(eff_n));
    assign item_a   = VW'(r_item.first_end);
    assign item_b   = VW'(r_item.second_end);
    assign item_hi  = ((item_a > item_b) ? CW'(item_a) : CW'(item_b)) + CW'(1);
    assign scan_idx = r_scan[VW-1:0];

    // Storage read data
    assign adj_present  = adj_rdata[W];
    assign adj_w        = adj_rdata[W-1:0];
    assign node_key_raw = node_rdata[NODE_W-1:VW];
    assign node_par     = node_rdata[VW-1:0];
    assign node_key     = r_reached[r_rd_idx] ? node_key_raw :
                          ((r_rd_idx == '0) ? '0 : pmst_pkg::KEY_MAX);

    // Shared compare unit
    always_comb begin
        cmp_req.in_weight  = r_item.edge_weight;
        cmp_req.adj_weight = adj_w;
        cmp_req.node_key   = node_key;
        cmp_req.best_key   = r_best_key;
        unique case (r_st)
            S_LCMP:   cmp_req.op = pmst_pkg::CMP_LOAD;
            S_SEARCH: cmp_req.op = pmst_pkg::CMP_SEARCH;
            default:  cmp_req.op = pmst_pkg::CMP_RELAX;
        endcase
    end

    pmst_cmp u_cmp (
        .i_req  (cmp_req),
        .o_less (cmp_less)
    );

    assign load_upd    = !adj_present || cmp_less;
    assign search_take = r_rd_vld && !r_visited[r_rd_idx] && (!r_found || cmp_less);
    assign relax_hit   = r_rd_vld && adj_present && !r_visited[r_rd_idx] && cmp_less;

    // Drive the matrix and vertex RAM ports
    always_comb begin
        adj_we     = 1'b0;
        adj_waddr  = '0;
        adj_wdata  = '0;
        adj_raddr  = '0;
        node_we    = 1'b0;
        node_waddr = '0;
        node_wdata = '0;
        node_raddr = '0;
        unique case (r_st)
            S_CLEAR: begin
                adj_we    = 1'b1;
                adj_waddr = r_clr;
            end
            S_LREAD: begin
                adj_raddr = {item_a, item_b};
            end
            S_LCMP: begin
                adj_we    = load_upd;
                adj_waddr = {item_a, item_b};
                adj_wdata = {1'b1, r_item.edge_weight};
            end
            S_LMIRROR: begin
                adj_we    = 1'b1;
                adj_waddr = {item_b, item_a};
                adj_wdata = {1'b1, r_item.edge_weight};
            end
            S_SEARCH: begin
                node_raddr = scan_idx;
            end
            S_RELAX: begin
                adj_raddr  = {r_best, scan_idx};
                node_raddr = scan_idx;
                // Drop each entry once read so the matrix is empty for the next graph
                adj_we     = r_rd_vld;
                adj_waddr  = {r_best, r_rd_idx};
                node_we    = relax_hit;
                node_waddr = r_rd_idx;
                node_wdata = {adj_w, r_best};
            end
            S_ORD: begin
                node_raddr = scan_idx;
            end
            default: begin
            end
        endcase
    end

    pmst_ram #(
        .WIDTH (W + 1),
        .DEPTH (ADJ_DEPTH)
    ) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (adj_waddr),
        .i_wdata (adj_wdata),
        .i_raddr (adj_raddr),
        .o_rdata (adj_rdata)
    );

    pmst_ram #(
        .WIDTH (NODE_W),
        .DEPTH (MAX_VERTICES)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (node_wdata),
        .i_raddr (node_raddr),
        .o_rdata (node_rdata)
    );

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= S_CLEAR;
            r_vcount    <= pmst_pkg::VCOUNT_RESET;
            r_scan      <= '0;
            r_rd_vld    <= 1'b0;
            r_round     <= '0;
            r_found     <= 1'b0;
            r_visited   <= '0;
            r_reached   <= '0;
            r_span      <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_write && (paddr[2] == pmst_pkg::REG_VERTEX_COUNT)) begin
                r_vcount <= pwdata[pmst_pkg::VCOUNT_BITS-1:0];
            end
            unique case (r_st)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == '1) begin
                        r_st <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_item <= i_edge;
                        if (i_edge.edge_valid && in_range) begin
                            r_st <= S_LREAD;
                        end else if (i_edge.last_edge) begin
                            r_st     <= S_SEARCH;
                            r_scan   <= '0;
                            r_rd_vld <= 1'b0;
                            r_found  <= 1'b0;
                            r_round  <= '0;
                        end
                    end
                end
                S_LREAD: begin
                    if (item_hi > r_span) begin
                        r_span <= item_hi;
                    end
                    r_st <= S_LCMP;
                end
                S_LCMP, S_LMIRROR: begin
                    if ((r_st == S_LCMP) && load_upd) begin
                        r_st <= S_LMIRROR;
                    end else if (r_item.last_edge) begin
                        r_st     <= S_SEARCH;
                        r_scan   <= '0;
                        r_rd_vld <= 1'b0;
                        r_found  <= 1'b0;
                        r_round  <= '0;
                    end else begin
                        r_st <= S_IDLE;
                    end
                end
                S_SEARCH: begin
                    // Advance the read pointer, keep the lowest-indexed least key
                    if (r_scan < eff_n) begin
                        r_scan   <= r_scan + 1'b1;
                        r_rd_vld <= 1'b1;
                        r_rd_idx <= scan_idx;
                    end else begin
                        r_rd_vld <= 1'b0;
                    end
                    if (search_take) begin
                        r_best     <= r_rd_idx;
                        r_best_key <= node_key;
                        r_found    <= 1'b1;
                    end
                    if ((r_scan == eff_n) && !r_rd_vld) begin
                        r_visited[r_best] <= 1'b1;
                        r_scan            <= '0;
                        r_st              <= S_RELAX;
                    end
                end
                S_RELAX: begin
                    if (r_scan < eff_n) begin
                        r_scan   <= r_scan + 1'b1;
                        r_rd_vld <= 1'b1;
                        r_rd_idx <= scan_idx;
                    end else begin
                        r_rd_vld <= 1'b0;
                    end
                    if (relax_hit) begin
                        r_reached[r_rd_idx] <= 1'b1;
                    end
                    if ((r_scan == eff_n) && !r_rd_vld) begin
                        r_round <= r_round + 1'b1;
                        r_found <= 1'b0;
                        if (r_round == (eff_n - 1'b1)) begin
                            r_scan <= CW'(1);
                            if (eff_n == CW'(1)) begin
                                r_st <= S_FINISH;
                            end else begin
                                r_st <= S_ORD;
                            end
                        end else begin
                            r_scan <= '0;
                            r_st   <= S_SEARCH;
                        end
                    end
                end
                S_ORD: begin
                    r_rd_idx <= scan_idx;
                    r_st     <= S_OLOAD;
                end
                S_OLOAD: begin
                    r_out.vertex_id   <= pmst_pkg::VERTEX_BITS'(r_scan);
                    r_out.parent_id   <= r_reached[r_rd_idx] ?
                                         pmst_pkg::VERTEX_BITS'(node_par) : '0;
                    r_out.tree_weight <= node_key;
                    r_out.reached     <= r_reached[r_rd_idx];
                    r_out.last_result <= (r_scan == (eff_n - 1'b1));
                    r_out_valid       <= 1'b1;
                    r_st              <= S_OWAIT;
                end
                S_OWAIT: begin
                    if (i_ready) begin
                        r_out_valid <= 1'b0;
                        if (r_scan == (eff_n - 1'b1)) begin
                            r_st <= S_FINISH;
                        end else begin
                            r_scan <= r_scan + 1'b1;
                            r_st   <= S_ORD;
                        end
                    end
                end
                S_FINISH: begin
                    // Reset the walk; sweep the matrix if edges lay outside the solved range
                    r_visited <= '0;
                    r_reached <= '0;
                    r_span    <= '0;
                    r_round   <= '0;
                    if (r_span > eff_n) begin
                        r_clr <= '0;
                        r_st  <= S_CLEAR;
                    end else begin
                        r_st <= S_IDLE;
                    end
                end
                default: begin
                    r_st <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready  = (r_st == S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    `PMST_ASSERT_IMPL(a_ready_no_result, i_clk, i_rst_n, o_ready, !o_valid)
    `PMST_ASSERT_IMPL(a_round_visits, i_clk, i_rst_n, r_st == S_SEARCH, $countones(r_visited) == int'(r_round))
    `PMST_ASSERT_IMPL(a_relax_unvisited, i_clk, i_rst_n, node_we, !r_visited[node_waddr] && r_visited[r_best])
    `PMST_ASSERT_NEXT(a_last_ends_results, i_clk, i_rst_n, o_valid && i_ready && o_result.last_result, !o_valid)

endmodule
